/* sv/dlr_pkg.sv */
// shared types and constants for the delta rgba line reconstruction block
// no dependencies
package dlr_pkg;

    // configuration register layout
    localparam int unsigned WIDTH_W    = 13;
    localparam int unsigned HEIGHT_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IMAGE_WIDTH   = 2'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT  = 2'd1;
    localparam t_cfg_idx CFG_ALPHA_ENABLED = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd4096;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd4096;

    // line store depth default
    localparam int unsigned MAX_WIDTH_DEF = 4096;

    // alpha value when alpha is disabled
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // one pixel, also the line store word
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix;

    // position of a pixel in the frame
    typedef struct packed {
        logic last_col;
        logic last_row;
        logic has_above;
    } t_pos_flags;

endpackage

/* sv/dlr_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module dlr_ram #(
    parameter int unsigned DATA_W = 32,
    parameter int unsigned DEPTH  = 4096,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/dlr_pos.sv */
// column and row counters with end-of-row and end-of-frame detection
// depends on dlr_pkg
module dlr_pos #(
    parameter int unsigned MAX_WIDTH = dlr_pkg::MAX_WIDTH_DEF,
    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic [dlr_pkg::WIDTH_W-1:0]    i_width,
    input  logic [dlr_pkg::HEIGHT_W-1:0]   i_height,
    output logic [COL_W-1:0]               o_col,
    output dlr_pkg::t_pos_flags            o_flags
);
    import dlr_pkg::*;

    localparam int unsigned MW_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned EW   = (WIDTH_W > MW_W) ? WIDTH_W : MW_W;
    localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

    logic [COL_W-1:0]    r_col, n_col;
    logic [HEIGHT_W-1:0] r_row, n_row;
    logic [EW-1:0]       w_ext;
    logic [EW-1:0]       w_m1;
    logic [HEIGHT_W-1:0] h_m1;
    logic                last_col;
    logic                last_row;

    // clamp width to 1..MAX_WIDTH and height to at least 1
    always_comb begin
        w_ext = EW'(i_width);
        priority if (w_ext == '0) begin
            w_m1 = '0;
        end else if (w_ext > MAXW) begin
            w_m1 = MAXW - EW'(1);
        end else begin
            w_m1 = w_ext - EW'(1);
        end
        h_m1 = (i_height == '0) ? '0 : i_height - HEIGHT_W'(1);
    end

    assign last_col = EW'(r_col) >= w_m1;
    assign last_row = r_row >= h_m1;

    // counter update on each accepted request
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + HEIGHT_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col             = r_col;
    assign o_flags.last_col  = last_col;
    assign o_flags.last_row  = last_row;
    assign o_flags.has_above = r_row != '0;

endmodule

/* sv/dlr_pix.sv */
// pixel datapath: green decorrelation, row running sums, add of pixel above
// depends on dlr_pkg
module dlr_pix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic                 i_alpha_en,
    input  dlr_pkg::t_pix        i_delta,
    input  dlr_pkg::t_pos_flags  i_flags,
    input  dlr_pkg::t_pix        i_above,
    output dlr_pkg::t_pix        o_pix
);
    import dlr_pkg::*;

    t_pix r_sum, n_sum;
    t_pix dec;
    t_pix sum_add;

    // add green into red and blue, drop alpha when disabled
    always_comb begin
        dec.green = i_delta.green;
        dec.red   = i_delta.red + i_delta.green;
        dec.blue  = i_delta.blue + i_delta.green;
        dec.alpha = i_alpha_en ? i_delta.alpha : 8'd0;
    end

    // running sums along the row
    always_comb begin
        sum_add.red   = r_sum.red + dec.red;
        sum_add.green = r_sum.green + dec.green;
        sum_add.blue  = r_sum.blue + dec.blue;
        sum_add.alpha = r_sum.alpha + dec.alpha;
    end

    // add the pixel above from the second row on
    always_comb begin
        o_pix = sum_add;
        if (i_flags.has_above) begin
            o_pix.red   = sum_add.red + i_above.red;
            o_pix.green = sum_add.green + i_above.green;
            o_pix.blue  = sum_add.blue + i_above.blue;
            o_pix.alpha = sum_add.alpha + i_above.alpha;
        end
        if (!i_alpha_en) begin
            o_pix.alpha = ALPHA_OPAQUE;
        end
    end

    // sums clear after the last pixel of a row
    always_comb begin
        n_sum = r_sum;
        if (i_fire) begin
            n_sum = i_flags.last_col ? '0 : sum_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

endmodule

/* sv/delta_rgba_line_reconstruct_core.sv */
// an accepted request passes through the stage 1 register and then the output register
// throughput: one pixel per cycle without output stalls, set by the 8-bit row sum loop and one line store port pair
// a same-column read in the cycle of its write (width 1) is served from a bypass register
// reset (synchronous, active low) clears counters, row sums and valid flags and loads
// the register defaults; the line store has no reset and no clearing pass
module delta_rgba_line_reconstruct_core #(
    parameter int unsigned MAX_WIDTH = dlr_pkg::MAX_WIDTH_DEF,
    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dlr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dlr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_blue_delta,
    input  logic [7:0]                      i_green_delta,
    input  logic [7:0]                      i_red_delta,
    input  logic [7:0]                      i_alpha_delta,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_red,
    output logic [7:0]                      o_out_green,
    output logic [7:0]                      o_out_blue,
    output logic [7:0]                      o_out_alpha,
    output logic                            o_end_of_row,
    output logic                            o_end_of_frame
);
    import dlr_pkg::*;

    logic [WIDTH_W-1:0]  r_cfg_width;
    logic [HEIGHT_W-1:0] r_cfg_height;
    logic                r_cfg_alpha;

    logic                r_s1_vld;
    t_pix                r_s1_delta;
    t_pos_flags          r_s1_flags;
    logic [COL_W-1:0]    r_s1_col;
    logic                r_byp_vld;
    t_pix                r_byp_pix;

    logic                r_out_vld;
    t_pix                r_out_pix;
    logic                r_out_eor;
    logic                r_out_eof;

    logic                in_accept;
    logic                s1_fire;
    logic [COL_W-1:0]    pos_col;
    t_pos_flags          pos_flags;
    t_pix                ram_rd;
    t_pix                above;
    t_pix                pix;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
            r_cfg_alpha  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_cfg_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  r_cfg_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_ALPHA_ENABLED: r_cfg_alpha  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: stage 1 moves when the output register is free or draining
    assign s1_fire    = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // frame position of the next request
    dlr_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (in_accept),
        .i_width  (r_cfg_width),
        .i_height (r_cfg_height),
        .o_col    (pos_col),
        .o_flags  (pos_flags)
    );

    // line store: read on accept, written as the pixel leaves stage 1
    dlr_ram #(
        .DATA_W ($bits(t_pix)),
        .DEPTH  (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data (pix),
        .i_rd_en   (in_accept),
        .i_rd_addr (pos_col),
        .o_rd_data (ram_rd)
    );

    // stage 1 input register and write-to-read bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_byp_vld <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_vld  <= 1'b1;
                r_byp_vld <= s1_fire && (r_s1_col == pos_col);
            end else if (s1_fire) begin
                r_s1_vld  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_delta.red   <= i_red_delta;
            r_s1_delta.green <= i_green_delta;
            r_s1_delta.blue  <= i_blue_delta;
            r_s1_delta.alpha <= i_alpha_delta;
            r_s1_flags       <= pos_flags;
            r_s1_col         <= pos_col;
            r_byp_pix        <= pix;
        end
    end

    assign above = r_byp_vld ? r_byp_pix : ram_rd;

    // pixel datapath
    dlr_pix u_pix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_fire),
        .i_alpha_en (r_cfg_alpha),
        .i_delta    (r_s1_delta),
        .i_flags    (r_s1_flags),
        .i_above    (above),
        .o_pix      (pix)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_pix <= pix;
            r_out_eor <= r_s1_flags.last_col;
            r_out_eof <= r_s1_flags.last_col && r_s1_flags.last_row;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_out_red      = r_out_pix.red;
    assign o_out_green    = r_out_pix.green;
    assign o_out_blue     = r_out_pix.blue;
    assign o_out_alpha    = r_out_pix.alpha;
    assign o_end_of_row   = r_out_eor;
    assign o_end_of_frame = r_out_eof;

`ifndef SYNTHESIS
    // an accepted request always occupies stage 1 next cycle
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_vld)
        else $error("accepted request missing from stage 1");

    // a pixel leaving stage 1 shows up on the output
    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_vld)
        else $error("stage 1 result lost");

    // no request taken while both stages are full and blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && i_out_stall) |-> o_in_stall)
        else $error("request accepted into a full pipeline");

    // frame end only on a row end
    a_eof_on_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out_eof || r_out_eor))
        else $error("end of frame without end of row");
`endif

endmodule

/* dv/delta_rgba_line_reconstruct_core_tb.sv */
// self-checking testbench for delta_rgba_line_reconstruct_core: directed and random pixel
// streams with bursty input and output stalls, checked against a behavioral pixel predictor
// depends on dlr_pkg and the core rtl
module delta_rgba_line_reconstruct_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlr_pkg::*;

    localparam int unsigned LINE_DEPTH   = MAX_WIDTH_DEF;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned WIDE_PIXELS  = 48;
    localparam int unsigned RANDOM_ITEMS = 470;

    // receiver stall behavior
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } t_stall_mode;

    // one reconstructed pixel as seen on the output channel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       end_of_row;
        logic       end_of_frame;
    } t_pixel_out;

    // dut ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index   = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_blue_delta  = '0;
    logic [7:0]            i_green_delta = '0;
    logic [7:0]            i_red_delta   = '0;
    logic [7:0]            i_alpha_delta = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [7:0]            o_out_red;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_blue;
    logic [7:0]            o_out_alpha;
    logic                  o_end_of_row;
    logic                  o_end_of_frame;

    // predictor state
    t_pix                  line_mem [LINE_DEPTH];
    bit                    line_written [LINE_DEPTH];
    logic [7:0]            sum_red   = '0;
    logic [7:0]            sum_green = '0;
    logic [7:0]            sum_blue  = '0;
    logic [7:0]            sum_alpha = '0;
    int unsigned           col_count = 0;
    int unsigned           row_count = 0;
    logic [WIDTH_W-1:0]    cfg_width  = WIDTH_RST;
    logic [HEIGHT_W-1:0]   cfg_height = HEIGHT_RST;
    logic                  cfg_alpha  = 1'b0;
    t_pixel_out            expected_pixels [$];

    // checking and traffic control
    int unsigned           mismatch_count = 0;
    int unsigned           idle_cycles    = 0;
    int unsigned           burst_left     = 0;
    bit                    steady_input   = 1'b0;
    t_stall_mode           out_stall_mode = STALL_NONE;
    int unsigned           hold_requests  = 0;
    int unsigned           holds_served   = 0;
    int unsigned           hold_len       = 0;
    int unsigned           hold_left      = 0;
    logic [7:0]            stall_bits     = 8'b0110_0010;
    t_pixel_out            got_pixel;
    t_pixel_out            want_pixel;

    delta_rgba_line_reconstruct_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_blue_delta   (i_blue_delta),
        .i_green_delta  (i_green_delta),
        .i_red_delta    (i_red_delta),
        .i_alpha_delta  (i_alpha_delta),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_out_alpha    (o_out_alpha),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // effective width after clamping to 1..line depth
    function automatic int unsigned eff_width(input logic [WIDTH_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > LINE_DEPTH)
            return LINE_DEPTH;
        return w;
    endfunction

    // a width change is safe unless it makes a lower row read a column never written
    function automatic bit width_allowed(input logic [CFG_DATA_W-1:0] data);
        int unsigned w;
        w = eff_width(data[WIDTH_W-1:0]);
        if (row_count == 0)
            return 1'b1;
        for (int unsigned i = 0; i < w; i++) begin
            if (!line_written[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // random byte with a bias toward the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // random width register data, mostly small rows
    function automatic logic [CFG_DATA_W-1:0] pick_width();
        logic [CFG_DATA_W-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = 16'd0;
            1:       d = 16'd1;
            2:       d = 16'($urandom_range(13, 40));
            default: d = 16'($urandom_range(2, 12));
        endcase
        if ($urandom_range(0, 5) == 0)
            d[15:13] = 3'($urandom);
        return d;
    endfunction

    // random height register data, mostly a few rows
    function automatic logic [CFG_DATA_W-1:0] pick_height();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(2, 6));
        endcase
    endfunction

    // alpha enable data with junk in the unused upper bits
    function automatic logic [CFG_DATA_W-1:0] alpha_data(input logic enable);
        return {15'($urandom), enable};
    endfunction

    function automatic string pixel_text(input t_pixel_out p);
        return $sformatf("r=%02h g=%02h b=%02h a=%02h eor=%0d eof=%0d",
                         p.red, p.green, p.blue, p.alpha, p.end_of_row, p.end_of_frame);
    endfunction

    // compute the pixel that one accepted request produces and queue it
    task automatic predict_pixel(input logic [7:0] b_d, g_d, r_d, a_d);
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned col;
        logic [7:0]  red_in;
        logic [7:0]  blue_in;
        logic [7:0]  alpha_in;
        t_pix        above;
        t_pixel_out  res;
        bit          last_col;
        bit          last_row;
        w_eff    = eff_width(cfg_width);
        h_eff    = (cfg_height == 0) ? 1 : cfg_height;
        alpha_in = cfg_alpha ? a_d : 8'h00;
        red_in   = r_d + g_d;
        blue_in  = b_d + g_d;

        // running sums along the row
        sum_red   = sum_red + red_in;
        sum_green = sum_green + g_d;
        sum_blue  = sum_blue + blue_in;
        sum_alpha = sum_alpha + alpha_in;
        res.red   = sum_red;
        res.green = sum_green;
        res.blue  = sum_blue;
        res.alpha = sum_alpha;

        // add the pixel above from the second row on
        col = (col_count >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_count;
        if (row_count > 0) begin
            above     = line_mem[col];
            res.red   = res.red + above.red;
            res.green = res.green + above.green;
            res.blue  = res.blue + above.blue;
            res.alpha = res.alpha + above.alpha;
        end
        if (!cfg_alpha)
            res.alpha = ALPHA_OPAQUE;

        line_mem[col]     = '{red: res.red, green: res.green, blue: res.blue,
                              alpha: res.alpha};
        line_written[col] = 1'b1;

        // row and frame position
        last_col         = (col_count >= w_eff - 1);
        last_row         = (row_count >= h_eff - 1);
        res.end_of_row   = last_col;
        res.end_of_frame = last_col && last_row;
        if (last_col) begin
            sum_red   = '0;
            sum_green = '0;
            sum_blue  = '0;
            sum_alpha = '0;
            col_count = 0;
            row_count = last_row ? 0 : ((row_count + 1) & 16'hffff);
        end else begin
            col_count = col_count + 1;
        end
        expected_pixels.push_back(res);
    endtask

    // present one request and hold it until accepted
    task automatic send_pixel(input logic [7:0] b, g, r, a);
        i_in_valid    <= 1'b1;
        i_blue_delta  <= b;
        i_green_delta <= g;
        i_red_delta   <= r;
        i_alpha_delta <= a;
        do @(posedge i_clk); while (o_in_stall);
        predict_pixel(b, g, r, a);
    endtask

    task automatic hold_input(input int unsigned n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // send with random bursts and gaps unless the input runs steady
    task automatic offer_pixel(input logic [7:0] b, g, r, a);
        int unsigned gap;
        if (!steady_input) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                hold_input(gap);
            end
            burst_left--;
        end
        send_pixel(b, g, r, a);
    endtask

    task automatic offer_random_pixel();
        offer_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    endtask

    // stop sending and wait for every outstanding pixel
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // register write; valid drops only after the last one of a group
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data,
                             input bit last_write);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last_write)
            i_cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:   cfg_width  = data[WIDTH_W-1:0];
            CFG_IMAGE_HEIGHT:  cfg_height = data[HEIGHT_W-1:0];
            CFG_ALPHA_ENABLED: cfg_alpha  = data[0];
            default: ;
        endcase
    endtask

    // finish the current frame quickly by cutting its height to one row
    task automatic close_frame();
        if (col_count != 0 || row_count != 0) begin
            drain_results();
            write_reg(CFG_IMAGE_HEIGHT, 16'd1, 1'b1);
            while (col_count != 0 || row_count != 0)
                offer_random_pixel();
        end
        drain_results();
    endtask

    // a few pixels under the reset register values
    task automatic test_reset_defaults();
        out_stall_mode = STALL_NONE;
        steady_input   = 1'b1;
        offer_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        offer_pixel(8'hff, 8'hff, 8'hff, 8'hff);
        offer_pixel(8'h01, 8'hff, 8'h01, 8'h80);
        drain_results();
    endtask

    // extremes, mid-frame changes, alpha toggling, clamped sizes, single column
    task automatic test_directed_cases();
        out_stall_mode = STALL_LIGHT;
        steady_input   = 1'b0;

        // shrink width below the current column, upper data bits are masked off
        write_reg(CFG_IMAGE_WIDTH, 16'he003, 1'b0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2, 1'b0);
        write_reg(CFG_ALPHA_ENABLED, alpha_data(1'b1), 1'b1);
        offer_pixel(8'hff, 8'hff, 8'hff, 8'hff);
        offer_pixel(8'h80, 8'h7f, 8'h01, 8'hfe);
        offer_pixel(8'h00, 8'h80, 8'hff, 8'h01);
        offer_pixel(8'hff, 8'h01, 8'h00, 8'hff);
        drain_results();

        // alpha off stores opaque alpha, then reused as the pixel above
        write_reg(CFG_ALPHA_ENABLED, alpha_data(1'b0), 1'b1);
        offer_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        offer_pixel(8'hfe, 8'h02, 8'h7f, 8'hff);
        offer_pixel(8'h01, 8'hff, 8'h80, 8'h55);
        drain_results();
        write_reg(CFG_ALPHA_ENABLED, alpha_data(1'b1), 1'b1);
        offer_pixel(8'h00, 8'h00, 8'h00, 8'h01);
        offer_pixel(8'hff, 8'hff, 8'hff, 8'h00);
        offer_pixel(8'haa, 8'h55, 8'hcc, 8'h33);
        drain_results();

        // zero width and zero height both count as one
        write_reg(CFG_IMAGE_WIDTH, 16'd0, 1'b0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0, 1'b1);
        offer_pixel(8'h10, 8'h20, 8'h30, 8'h40);
        offer_pixel(8'hff, 8'h00, 8'hff, 8'h00);
        offer_pixel(8'h00, 8'hff, 8'h00, 8'hff);
        drain_results();

        // single column: each row reads the word written just before
        write_reg(CFG_IMAGE_WIDTH, 16'd1, 1'b0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3, 1'b1);
        steady_input = 1'b1;
        offer_pixel(8'hf0, 8'h0f, 8'h3c, 8'hc3);
        offer_pixel(8'h0f, 8'hf0, 8'hc3, 8'h3c);
        offer_pixel(8'hff, 8'hff, 8'hff, 8'hff);
        offer_pixel(8'h01, 8'h01, 8'h01, 8'h01);
        drain_results();

        // tallest frame, left open and closed afterwards
        write_reg(CFG_IMAGE_WIDTH, 16'd2, 1'b0);
        write_reg(CFG_IMAGE_HEIGHT, 16'hffff, 1'b1);
        steady_input = 1'b0;
        offer_pixel(8'h7f, 8'h80, 8'h7f, 8'h80);
        offer_pixel(8'h80, 8'h7f, 8'h80, 8'h7f);
        offer_pixel(8'hff, 8'h00, 8'h00, 8'hff);
        offer_pixel(8'h00, 8'hff, 8'hff, 8'h00);
        close_frame();
    endtask

    // oversized width register clamps and keeps the row open, then a narrow width ends it
    task automatic test_wide_rows();
        close_frame();
        write_reg(CFG_IMAGE_WIDTH, 16'h1001, 1'b0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2, 1'b0);
        write_reg(CFG_ALPHA_ENABLED, alpha_data(1'b1), 1'b1);
        for (int unsigned k = 0; k < WIDE_PIXELS; k++) begin
            if (k % 16 == 0) begin
                out_stall_mode = t_stall_mode'($urandom_range(0, 3));
                steady_input   = ($urandom_range(0, 2) == 0);
            end
            offer_random_pixel();
        end
        drain_results();
        write_reg(CFG_IMAGE_WIDTH, 16'd2, 1'b1);
        while (col_count != 0 || row_count != 0)
            offer_random_pixel();
        drain_results();
    endtask

    // long receiver hold-off while the sender keeps offering, then patterned stalls with bursty input
    task automatic test_backpressure();
        drain_results();
        out_stall_mode = STALL_NONE;
        steady_input   = 1'b1;
        hold_len       = 150;
        hold_requests  = hold_requests + 1;
        repeat (40) offer_random_pixel();
        drain_results();
        out_stall_mode = STALL_PATTERN;
        steady_input   = 1'b0;
        repeat (30) offer_random_pixel();
        drain_results();
    endtask

    // random frames in phases with reconfiguration between them
    task automatic test_random_stream(input int unsigned n_items);
        int unsigned           sent;
        int unsigned           phase_len;
        logic [CFG_DATA_W-1:0] d;
        sent = 0;
        while (sent < n_items) begin
            drain_results();
            if ($urandom_range(0, 2) == 0) begin
                // new frame with fresh settings
                close_frame();
                write_reg(CFG_IMAGE_WIDTH, pick_width(), 1'b0);
                write_reg(CFG_IMAGE_HEIGHT, pick_height(), 1'b0);
                write_reg(CFG_ALPHA_ENABLED, alpha_data(1'($urandom)), 1'b1);
            end else begin
                // change one register in the middle of a frame
                case ($urandom_range(0, 2))
                    0: begin
                        d = pick_width();
                        if (width_allowed(d))
                            write_reg(CFG_IMAGE_WIDTH, d, 1'b1);
                    end
                    1:       write_reg(CFG_IMAGE_HEIGHT, pick_height(), 1'b1);
                    default: write_reg(CFG_ALPHA_ENABLED, alpha_data(1'($urandom)), 1'b1);
                endcase
            end
            steady_input   = ($urandom_range(0, 3) == 0);
            out_stall_mode = t_stall_mode'($urandom_range(0, 3));
            phase_len      = $urandom_range(10, 60);
            repeat (phase_len) offer_random_pixel();
            sent += phase_len;
        end
        drain_results();
    endtask

    // receiver stall generator with a counted long hold-off
    always @(posedge i_clk) begin
        stall_bits <= {stall_bits[6:0], stall_bits[7]};
        if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left    <= hold_len;
            i_out_stall  <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (out_stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
                default:     i_out_stall <= stall_bits[0];
            endcase
        end
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < REPORT_LIMIT)
            $display("%s", msg);
        mismatch_count++;
    endtask

    // compare each accepted pixel with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_pixel = '{red: o_out_red, green: o_out_green, blue: o_out_blue,
                          alpha: o_out_alpha, end_of_row: o_end_of_row,
                          end_of_frame: o_end_of_frame};
            if (expected_pixels.size() == 0) begin
                flag_mismatch($sformatf("unexpected pixel: %s", pixel_text(got_pixel)));
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (got_pixel.red !== want_pixel.red ||
                    got_pixel.green !== want_pixel.green ||
                    got_pixel.blue !== want_pixel.blue ||
                    got_pixel.alpha !== want_pixel.alpha ||
                    got_pixel.end_of_row !== want_pixel.end_of_row ||
                    got_pixel.end_of_frame !== want_pixel.end_of_frame)
                    flag_mismatch($sformatf("pixel mismatch: expected %s, got %s",
                                            pixel_text(want_pixel), pixel_text(got_pixel)));
            end
        end
    end

    // watchdog on cycles with no accepted request on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_cases();
        test_wide_rows();
        test_backpressure();
        test_random_stream(RANDOM_ITEMS);

        // final drain and settle
        out_stall_mode = STALL_NONE;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
sv/dlr_pkg.sv
sv/dlr_ram.sv
sv/dlr_pos.sv
sv/dlr_pix.sv
sv/delta_rgba_line_reconstruct_core.sv
dv/delta_rgba_line_reconstruct_core_tb.sv
